// File: rtl/core/bsra_pkg.sv
// Package for bond_stress_ratio_argmax: widths, direction codes and the
// controller/datapath command and status structs. No dependencies.
package bsra_pkg;
    localparam int DATA_BITS  = 32;
    localparam int COORD_BITS = 10;
    localparam int DIR_BITS   = 2;
    localparam int GRID_BITS  = 11;
    localparam int GRID_MAX   = 1024;
    localparam int CNT_BITS   = $clog2(DATA_BITS);

    localparam logic [DIR_BITS-1:0] DIR_RIGHT = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_BACK  = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_TOP   = 2'd2;

    localparam logic CFG_STIFFNESS = 1'b0;
    localparam logic CFG_GRID_SIZE = 1'b1;

    localparam logic [DATA_BITS-1:0] STIFF_RESET = 32'h0100_0000;
    localparam logic [GRID_BITS-1:0] GRID_RESET  = 11'd64;

    typedef struct packed {
        logic load;
        logic mul_cs;
        logic mul_d;
        logic sum;
        logic div_step;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic sat;
        logic last;
        logic out_busy;
    } t_sts;
endpackage

// File: rtl/core/bsra_if.sv
// Channel interfaces for bond_stress_ratio_argmax: bond words in, result
// words out. Depends on bsra_pkg.
interface bsra_in_if;
    logic                                valid;
    logic                                ready;
    logic [bsra_pkg::COORD_BITS-1:0]     node_x;
    logic [bsra_pkg::COORD_BITS-1:0]     node_y;
    logic [bsra_pkg::COORD_BITS-1:0]     node_z;
    logic [bsra_pkg::DIR_BITS-1:0]       bond_dir;
    logic [bsra_pkg::DATA_BITS-1:0]      conductance;
    logic signed [bsra_pkg::DATA_BITS-1:0] potential_here;
    logic signed [bsra_pkg::DATA_BITS-1:0] potential_next;
    logic [bsra_pkg::DATA_BITS-1:0]      threshold;
    logic                                last_bond;
    modport source (output valid, node_x, node_y, node_z, bond_dir, conductance,
                    potential_here, potential_next, threshold, last_bond,
                    input ready);
    modport sink   (input valid, node_x, node_y, node_z, bond_dir, conductance,
                    potential_here, potential_next, threshold, last_bond,
                    output ready);
endinterface

interface bsra_out_if;
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [bsra_pkg::COORD_BITS-1:0] best_x;
    logic [bsra_pkg::COORD_BITS-1:0] best_y;
    logic [bsra_pkg::COORD_BITS-1:0] best_z;
    logic [bsra_pkg::DIR_BITS-1:0]   best_dir;
    logic [bsra_pkg::DATA_BITS-1:0]  best_ratio;
    modport source (output valid, found, best_x, best_y, best_z, best_dir, best_ratio,
                    input ready);
    modport sink   (input valid, found, best_x, best_y, best_z, best_dir, best_ratio,
                    output ready);
endinterface

// File: rtl/core/bsra_ctrl.sv
// Controller FSM for bond_stress_ratio_argmax: sequences multiply, sum,
// divide and update steps for one bond word. Depends on bsra_pkg.
module bsra_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bsra_pkg::t_sts   i_sts,
    output bsra_pkg::t_cmd   o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;

    logic [2:0]                   r_state, n_state;
    logic [bsra_pkg::CNT_BITS-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul_cs = 1'b1;
                n_state      = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_d = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_sts.sat) begin
                    n_state = S_UPD;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                    if (&r_cnt) n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (!(i_sts.last && i_sts.out_busy)) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule

// File: rtl/core/bsra_dp.sv
// Datapath for bond_stress_ratio_argmax: config registers, multiplies,
// bit-serial divider, running max and output register. Depends on bsra_pkg.
module bsra_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bsra_pkg::t_cmd i_cmd,
    output bsra_pkg::t_sts o_sts,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [bsra_pkg::DATA_BITS-1:0] i_cfg_data,
    bsra_in_if.sink        i_bond,
    bsra_out_if.source     o_res
);
    localparam int DW = bsra_pkg::DATA_BITS;
    localparam int CW = bsra_pkg::COORD_BITS;
    localparam int GW = bsra_pkg::GRID_BITS;

    logic [DW-1:0]       r_stiff;
    logic [GW-1:0]       r_grid;
    logic [CW-1:0]       r_x, r_y, r_z;
    logic [1:0]          r_dir;
    logic [DW-1:0]       r_cond, r_mag, r_thr;
    logic                r_last, r_ok;
    logic [2*DW-1:0]     r_p, r_pa, r_pb;
    logic [DW-1:0]       r_rem, r_dvd, r_q;
    logic                r_sat;
    logic [DW-1:0]       r_max;
    logic                r_have;
    logic [CW-1:0]       r_kx, r_ky, r_kz;
    logic [1:0]          r_kdir;
    logic                r_ov, r_found;
    logic [CW-1:0]       r_ox, r_oy, r_oz;
    logic [1:0]          r_odir;
    logic [DW-1:0]       r_oratio;

    logic [GW-1:0]       n_lim;
    logic                in_ok, along_ok;
    logic signed [DW:0]  diff;
    logic [2*DW-1:0]     sum_x;
    logic [DW:0]         rem2;
    logic                ge;
    logic [DW:0]         rem_sub;
    logic [DW-1:0]       ratio;
    logic                win;
    logic                n_have;
    logic [DW-1:0]       n_max;
    logic [CW-1:0]       n_kx, n_ky, n_kz;
    logic [1:0]          n_kdir;

    always_comb begin
        n_lim = (r_grid > GW'(bsra_pkg::GRID_MAX)) ? GW'(bsra_pkg::GRID_MAX) : r_grid;
        unique case (i_bond.bond_dir)
            bsra_pkg::DIR_RIGHT: along_ok = {1'b0, i_bond.node_x} < (n_lim - 1'b1);
            bsra_pkg::DIR_BACK:  along_ok = {1'b0, i_bond.node_y} < (n_lim - 1'b1);
            bsra_pkg::DIR_TOP:   along_ok = {1'b0, i_bond.node_z} < (n_lim - 1'b1);
            default:             along_ok = 1'b0;
        endcase
        in_ok = (n_lim >= GW'(2)) && ({1'b0, i_bond.node_x} < n_lim)
              && ({1'b0, i_bond.node_y} < n_lim) && ({1'b0, i_bond.node_z} < n_lim)
              && along_ok;
        diff  = {i_bond.potential_next[DW-1], i_bond.potential_next}
              - {i_bond.potential_here[DW-1], i_bond.potential_here};
    end

    assign sum_x   = {{DW{1'b0}}, r_pa[2*DW-1:DW]} + r_pb;
    assign rem2    = {r_rem, r_dvd[DW-1]};
    assign ge      = rem2 >= {1'b0, r_thr};
    assign rem_sub = rem2 - {1'b0, r_thr};
    assign ratio   = r_sat ? {DW{1'b1}} : r_q;
    assign win     = r_ok && (!r_have || (ratio > r_max));

    always_comb begin
        n_have = r_have;
        n_max  = r_max;
        n_kx   = r_kx;
        n_ky   = r_ky;
        n_kz   = r_kz;
        n_kdir = r_kdir;
        if (win) begin
            n_have = 1'b1;
            n_max  = ratio;
            n_kx   = r_x;
            n_ky   = r_y;
            n_kz   = r_z;
            n_kdir = r_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_bond.node_x;
            r_y    <= i_bond.node_y;
            r_z    <= i_bond.node_z;
            r_dir  <= i_bond.bond_dir;
            r_cond <= i_bond.conductance;
            r_thr  <= i_bond.threshold;
            r_last <= i_bond.last_bond;
            r_ok   <= in_ok;
            r_mag  <= diff[DW] ? DW'(-diff) : diff[DW-1:0];
        end
        if (i_cmd.mul_cs) r_p <= r_cond * r_stiff;
        if (i_cmd.mul_d) begin
            r_pa <= r_p[DW-1:0] * r_mag;
            r_pb <= r_p[2*DW-1:DW] * r_mag;
        end
        if (i_cmd.sum) begin
            r_rem <= sum_x[2*DW-1:DW];
            r_dvd <= sum_x[DW-1:0];
            r_sat <= sum_x[2*DW-1:DW] >= r_thr;
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? rem_sub[DW-1:0] : rem2[DW-1:0];
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_q   <= {r_q[DW-2:0], ge};
        end
        if (i_cmd.update && r_last) begin
            r_found  <= n_have;
            r_ox     <= n_kx;
            r_oy     <= n_ky;
            r_oz     <= n_kz;
            r_odir   <= n_kdir;
            r_oratio <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= bsra_pkg::STIFF_RESET;
            r_grid  <= bsra_pkg::GRID_RESET;
            r_have  <= 1'b0;
            r_max   <= '0;
            r_kx    <= '0;
            r_ky    <= '0;
            r_kz    <= '0;
            r_kdir  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bsra_pkg::CFG_STIFFNESS: r_stiff <= i_cfg_data;
                    bsra_pkg::CFG_GRID_SIZE: r_grid  <= i_cfg_data[GW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.update) begin
                if (r_last) begin
                    r_have <= 1'b0;
                    r_max  <= '0;
                    r_kx   <= '0;
                    r_ky   <= '0;
                    r_kz   <= '0;
                    r_kdir <= '0;
                end else begin
                    r_have <= n_have;
                    r_max  <= n_max;
                    r_kx   <= n_kx;
                    r_ky   <= n_ky;
                    r_kz   <= n_kz;
                    r_kdir <= n_kdir;
                end
            end
            if (i_cmd.update && r_last) r_ov <= 1'b1;
            else if (o_res.ready)       r_ov <= 1'b0;
        end
    end

    assign o_sts.sat      = r_sat;
    assign o_sts.last     = r_last;
    assign o_sts.out_busy = r_ov && !o_res.ready;

    assign o_res.valid      = r_ov;
    assign o_res.found      = r_found;
    assign o_res.best_x     = r_ox;
    assign o_res.best_y     = r_oy;
    assign o_res.best_z     = r_oz;
    assign o_res.best_dir   = r_odir;
    assign o_res.best_ratio = r_oratio;
endmodule

// File: rtl/core/bond_stress_ratio_argmax.sv
// Top level of bond_stress_ratio_argmax: joins controller and datapath.
// Depends on bsra_pkg, bsra_if, bsra_ctrl, bsra_dp.
//
// Usage: bond words enter on i_bond (valid/ready); one result word leaves
// on o_res after each word flagged last_bond. Config writes go through
// i_cfg_we / i_cfg_idx (0 stiffness, 1 grid_size) / i_cfg_data while idle.
// Each word takes one bond: accept, multiply C*S, multiply by |dP|, sum,
// then a one-bit-per-cycle restoring divider (skipped when the quotient
// saturates), then an update step. The divider sets the rate; a new word
// is taken the cycle after the update, so one word is in flight at a time.
// o_res.valid is set by the update of a last word.
// The result sits in an output register; while it waits, non-last words
// keep flowing. A last word waits in its update cycle only while the
// previous result is still stalled.
// Synchronous active-low reset clears the sweep state and the output valid,
// and restores stiffness 1.0 and grid_size 64.
module bond_stress_ratio_argmax (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [bsra_pkg::DATA_BITS-1:0] i_cfg_data,
    bsra_in_if.sink                        i_bond,
    bsra_out_if.source                     o_res
);
    bsra_pkg::t_cmd cmd;
    bsra_pkg::t_sts sts;

    bsra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_bond.valid),
        .o_in_ready (i_bond.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bsra_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_bond     (i_bond),
        .o_res      (o_res)
    );
endmodule

// File: rtl/core/bsra_checker.sv
// Port-level checker for bond_stress_ratio_argmax, bound to the top level.
// Depends on bsra_pkg.
module bsra_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            found,
    input logic [bsra_pkg::DIR_BITS-1:0]   best_dir,
    input logic [bsra_pkg::DATA_BITS-1:0]  best_ratio
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(best_ratio))
        else $error("result word dropped or changed under stall");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second bond word taken while one is in flight");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !found |-> best_ratio == '0 && best_dir == '0)
        else $error("empty sweep with nonzero result");

    a_dir_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> best_dir != 2'd3)
        else $error("illegal winning direction");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid && in_ready)
        else $error("block not idle after reset");
endmodule

bind bond_stress_ratio_argmax bsra_checker u_bsra_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (i_bond.valid),
    .in_ready   (i_bond.ready),
    .out_valid  (o_res.valid),
    .out_ready  (o_res.ready),
    .found      (o_res.found),
    .best_dir   (o_res.best_dir),
    .best_ratio (o_res.best_ratio)
);

// File: verif/bond_stress_ratio_argmax_tb.sv
// Testbench for bond_stress_ratio_argmax: random and directed bond sweeps,
// checked word by word against an in-bench argmax predictor.
// Depends on bsra_pkg, bsra_if and the RTL of bond_stress_ratio_argmax.
`timescale 1ns / 1ps

module bond_stress_ratio_argmax_tb;
    typedef struct {
        logic [bsra_pkg::COORD_BITS-1:0] x, y, z;
        logic [bsra_pkg::DIR_BITS-1:0]   dir;
        logic [bsra_pkg::DATA_BITS-1:0]  cond;
        logic [bsra_pkg::DATA_BITS-1:0]  here, next;
        logic [bsra_pkg::DATA_BITS-1:0]  thr;
        logic                            last;
    } t_bond;

    typedef struct {
        logic                            found;
        logic [bsra_pkg::COORD_BITS-1:0] x, y, z;
        logic [bsra_pkg::DIR_BITS-1:0]   dir;
        logic [bsra_pkg::DATA_BITS-1:0]  ratio;
    } t_best;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = bsra_pkg::CFG_STIFFNESS;
    logic [bsra_pkg::DATA_BITS-1:0] i_cfg_data = '0;

    bsra_in_if  bond_if ();
    bsra_out_if res_if ();

    bond_stress_ratio_argmax DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_bond     (bond_if),
        .o_res      (res_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_bond bond_queue[$];
    t_best best_queue[$];
    int    mismatches = 0;
    bit    jitter_on = 1'b1;
    int    hold_req = 0;

    // predictor copy of registers and sweep state
    logic [bsra_pkg::DATA_BITS-1:0] stiff_reg = bsra_pkg::STIFF_RESET;
    logic [bsra_pkg::GRID_BITS-1:0] grid_reg  = bsra_pkg::GRID_RESET;
    t_best sweep_best = '{default: '0};

    function automatic logic [bsra_pkg::DATA_BITS-1:0] stress_of(
            logic [bsra_pkg::DATA_BITS-1:0] c, logic [bsra_pkg::DATA_BITS-1:0] s,
            logic [bsra_pkg::DATA_BITS:0] d, logic [bsra_pkg::DATA_BITS-1:0] t);
        logic [127:0] num;
        logic [127:0] q;
        num = 128'(c) * 128'(s) * 128'(d);
        if (t == 0) return '1;
        q = num / {64'd0, t, 32'd0};
        if (q > 128'hFFFF_FFFF) return '1;
        return q[bsra_pkg::DATA_BITS-1:0];
    endfunction

    function automatic int grid_eff();
        return (grid_reg > bsra_pkg::GRID_MAX) ? bsra_pkg::GRID_MAX : int'(grid_reg);
    endfunction

    task automatic track_bond(t_bond b);
        int n;
        bit inside_grid;
        longint signed d;
        logic [bsra_pkg::DATA_BITS:0] mag;
        logic [bsra_pkg::DATA_BITS-1:0] r;
        n = grid_eff();
        inside_grid = 1'b0;
        if (n >= 2 && b.x < n && b.y < n && b.z < n) begin
            case (b.dir)
                bsra_pkg::DIR_RIGHT: inside_grid = b.x < n - 1;
                bsra_pkg::DIR_BACK:  inside_grid = b.y < n - 1;
                bsra_pkg::DIR_TOP:   inside_grid = b.z < n - 1;
                default:             inside_grid = 1'b0;
            endcase
        end
        if (inside_grid) begin
            d = longint'($signed(b.next)) - longint'($signed(b.here));
            mag = (d < 0) ? 33'(-d) : 33'(d);
            r = stress_of(b.cond, stiff_reg, mag, b.thr);
            if (!sweep_best.found || r > sweep_best.ratio)
                sweep_best = '{1'b1, b.x, b.y, b.z, b.dir, r};
        end
        if (b.last) begin
            best_queue.push_back(sweep_best);
            sweep_best = '{default: '0};
        end
    endtask

    // driver
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_bond b;
        if (i_rst_n) begin
            if (bond_if.valid && bond_if.ready) begin
                b = '{bond_if.node_x, bond_if.node_y, bond_if.node_z, bond_if.bond_dir,
                      bond_if.conductance, bond_if.potential_here, bond_if.potential_next,
                      bond_if.threshold, bond_if.last_bond};
                track_bond(b);
            end
            if (!bond_if.valid || bond_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    bond_if.valid <= 1'b0;
                end else if (bond_queue.size() > 0) begin
                    b = bond_queue.pop_front();
                    bond_if.node_x         <= b.x;
                    bond_if.node_y         <= b.y;
                    bond_if.node_z         <= b.z;
                    bond_if.bond_dir       <= b.dir;
                    bond_if.conductance    <= b.cond;
                    bond_if.potential_here <= b.here;
                    bond_if.potential_next <= b.next;
                    bond_if.threshold      <= b.thr;
                    bond_if.last_bond      <= b.last;
                    bond_if.valid          <= 1'b1;
                    if (jitter_on && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 4);
                end else begin
                    bond_if.valid <= 1'b0;
                end
            end
        end
    end

    // result side: random stalls plus long hold-off on request
    int stall_left = 0;
    int hold_seen = 0;
    always @(posedge i_clk) begin
        t_best got, want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = '{res_if.found, res_if.best_x, res_if.best_y, res_if.best_z,
                        res_if.best_dir, res_if.best_ratio};
                if (best_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: found=%0d ratio=%h",
                                 got.found, got.ratio);
                end else begin
                    want = best_queue.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: exp f=%0d x=%0d y=%0d z=%0d d=%0d r=%h",
                                      " got f=%0d x=%0d y=%0d z=%0d d=%0d r=%h"},
                                     want.found, want.x, want.y, want.z, want.dir,
                                     want.ratio, got.found, got.x, got.y, got.z,
                                     got.dir, got.ratio);
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                stall_left = 400;
            end else if (stall_left == 0 && jitter_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no word moving
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((bond_if.valid && bond_if.ready) || (res_if.valid && res_if.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= 5000) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_bond(int x, int y, int z, int dir, logic [31:0] c,
                            logic [31:0] h, logic [31:0] n, logic [31:0] t, bit last);
        bond_queue.push_back('{x[9:0], y[9:0], z[9:0], dir[1:0], c, h, n, t, last});
    endtask

    function automatic logic [31:0] rand_mag();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic int rand_coord();
        int n;
        n = grid_eff();
        if ($urandom_range(0, 7) == 0 || n > 1021) return $urandom_range(0, 1023);
        return $urandom_range(0, n + 1);
    endfunction

    task automatic add_sweeps(int count, int max_len);
        int len;
        logic [31:0] h;
        for (int i = 0; i < count; i++) begin
            len = $urandom_range(1, max_len);
            for (int k = 0; k < len; k++) begin
                h = $urandom;
                add_bond(rand_coord(), rand_coord(), rand_coord(),
                         ($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2),
                         ($urandom_range(0, 9) == 0) ? 32'd0 : rand_mag(), h,
                         ($urandom_range(0, 1)) ? $urandom : h + (rand_mag() >> 4),
                         ($urandom_range(0, 19) == 0) ? 32'd0 : rand_mag() | 32'd1,
                         k == len - 1);
            end
        end
    endtask

    task automatic wait_idle();
        while (bond_queue.size() > 0 || best_queue.size() > 0 || bond_if.valid)
            @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bsra_pkg::CFG_STIFFNESS) stiff_reg = data;
        else grid_reg = data[bsra_pkg::GRID_BITS-1:0];
    endtask

    initial begin
        bond_if.valid = 1'b0;
        bond_if.node_x = '0;
        bond_if.node_y = '0;
        bond_if.node_z = '0;
        bond_if.bond_dir = '0;
        bond_if.conductance = '0;
        bond_if.potential_here = '0;
        bond_if.potential_next = '0;
        bond_if.threshold = '0;
        bond_if.last_bond = 1'b0;
        res_if.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset config: grid 64, stiffness 1.0
        add_bond(63, 0, 0, 0, 32'h0100_0000, 0, 32'h0100_0000, 32'h0100_0000, 1);
        add_bond(1, 1, 1, 3, 32'h0100_0000, 0, 32'h0100_0000, 32'h0100_0000, 1);
        add_bond(62, 0, 0, 0, 32'h0100_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0);
        add_bond(0, 0, 62, 2, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0);
        add_bond(0, 63, 0, 1, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 1, 0);
        add_bond(5, 5, 5, 1, 0, 0, 32'h7FFF_FFFF, 1, 1);
        add_bond(3, 3, 3, 0, 32'h0200_0000, 0, 32'h0100_0000, 0, 1);
        add_bond(4, 4, 4, 0, 32'h0100_0000, 0, 32'h0300_0000, 32'h0100_0000, 0);
        add_bond(7, 8, 9, 2, 32'h0100_0000, 32'h0300_0000, 0, 32'h0100_0000, 0);
        add_bond(1, 2, 3, 1, 32'h0080_0000, 0, 32'h0100_0000, 32'h0100_0000, 1);
        add_bond(0, 62, 0, 1, 0, 32'h1234_5678, 32'hFEDC_BA98, 32'hFFFF_FFFF, 1);
        add_bond(0, 0, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        add_bond(63, 63, 63, 2, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 1, 0);
        add_bond(61, 61, 61, 0, 32'h0000_0001, 0, 1, 32'hFFFF_FFFF, 1);
        wait_idle();

        add_sweeps(40, 8);
        wait_idle();

        // result side holds off while bonds keep coming
        hold_req++;
        add_sweeps(30, 2);
        wait_idle();

        write_reg(bsra_pkg::CFG_STIFFNESS, 32'd0);
        write_reg(bsra_pkg::CFG_GRID_SIZE, 32'd2);
        add_sweeps(15, 6);
        wait_idle();

        write_reg(bsra_pkg::CFG_STIFFNESS, 32'hFFFF_FFFF);
        write_reg(bsra_pkg::CFG_GRID_SIZE, 32'd1024);
        add_sweeps(20, 8);
        wait_idle();

        write_reg(bsra_pkg::CFG_STIFFNESS, $urandom);
        write_reg(bsra_pkg::CFG_GRID_SIZE, 32'd2047);
        add_sweeps(15, 6);
        wait_idle();

        write_reg(bsra_pkg::CFG_GRID_SIZE, 32'd0);
        add_sweeps(5, 4);
        wait_idle();
        write_reg(bsra_pkg::CFG_GRID_SIZE, 32'd1);
        add_sweeps(5, 4);
        wait_idle();

        write_reg(bsra_pkg::CFG_STIFFNESS, 32'h0040_0000);
        write_reg(bsra_pkg::CFG_GRID_SIZE, 32'd3);
        add_sweeps(20, 5);
        wait_idle();

        write_reg(bsra_pkg::CFG_STIFFNESS, 32'h0100_0000);
        write_reg(bsra_pkg::CFG_GRID_SIZE, 32'd16);
        add_sweeps(40, 8);
        wait_idle();

        jitter_on = 1'b0;
        add_sweeps(25, 8);
        while (bond_queue.size() > 0 || best_queue.size() > 0 || bond_if.valid)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/core/bsra_pkg.sv
rtl/core/bsra_if.sv
rtl/core/bsra_ctrl.sv
rtl/core/bsra_dp.sv
rtl/core/bond_stress_ratio_argmax.sv
rtl/core/bsra_checker.sv
verif/bond_stress_ratio_argmax_tb.sv
